>>> rtl/core/aoce_pkg.sv
package aoce_pkg;

    // geometry and capacity
    localparam int unsigned MapHeight = 64;
    localparam int unsigned MapWidth  = 64;
    localparam int unsigned Layers    = 16;
    localparam int unsigned OpenDepth = 1024;

    localparam int unsigned HeapAw    = $clog2(OpenDepth);
    localparam int unsigned CountW    = 11;
    localparam int unsigned EntryW    = 64;
    localparam int unsigned BmRowW    = MapWidth;
    localparam int unsigned BmDepth   = MapHeight * Layers;
    localparam int unsigned BmAw      = $clog2(BmDepth);

    // operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [3:0]  layer;
        logic [31:0] cost;
        logic [15:0] node_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        expanded;
        logic [5:0]  best_row;
        logic [5:0]  best_col;
        logic [3:0]  best_layer;
        logic [31:0] best_cost;
        logic [15:0] best_handle;
        logic [10:0] discarded_count;
        logic [10:0] open_count;
    } rsp_t;

    // heap entry, unsigned order of the packed word is the priority order
    typedef struct packed {
        logic [31:0] cost;
        logic [15:0] handle;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [3:0]  layer;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PU_CHK,
        S_PU_CMP,
        S_PO_ROOT,
        S_PO_LAST,
        S_SD_L,
        S_SD_LQ,
        S_SD_RQ,
        S_SD_CMP,
        S_PO_NEXT,
        S_BM,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/aoce_ram.sv
module aoce_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/astar_open_closed_engine.sv
// Open list as a binary min-heap in a 1024 x 64 RAM, closed set as a 1024 x 64 bitmap RAM
// (one row per layer and grid row, one bit per column). A request is taken when start is
// high and busy is low; its response appears for one cycle with done high and cannot be
// stalled. After reset the bitmap is swept to zero with busy high. Mark and query read the
// closed row of the request, then write it back with the bit set or report the bit. A push
// climbs one heap level at a time, moving each larger parent down, and writes the entry
// where it stops. A pop takes the root, fetches the last entry and the root's closed row, and
// sifts down, children read in turn on the one heap read port; each closed entry repeats it.
module astar_open_closed_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  aoce_pkg::req_t req,
    output logic           done,
    output aoce_pkg::rsp_t rsp
);
    import aoce_pkg::*;

    state_t state_reg, state_next;

    req_t               req_reg, req_next;
    entry_t             v_reg, v_next;
    entry_t             e_reg, e_next;
    entry_t             c_reg, c_next;
    logic [CountW-1:0]  ci_reg, ci_next;
    logic [HeapAw-1:0]  i_reg, i_next;
    logic [CountW-1:0]  size_reg, size_next;
    logic [CountW-1:0]  disc_reg, disc_next;
    logic               closed_reg, closed_next;
    logic [1:0]         status_reg, status_next;
    logic               exp_reg, exp_next;
    logic               found_reg, found_next;
    logic [BmAw-1:0]    clr_reg, clr_next;

    // memory ports
    logic               h_we;
    logic [HeapAw-1:0]  h_waddr, h_raddr;
    entry_t             h_wdata, h_q;
    logic               b_we;
    logic [BmAw-1:0]    b_waddr, b_raddr;
    logic [BmRowW-1:0]  b_wdata, b_q;

    logic [CountW-1:0]  left_idx;
    logic [CountW-1:0]  size_dec;
    logic [HeapAw-1:0]  parent_idx;
    logic [BmAw-1:0]    req_row_addr;

    assign left_idx     = {i_reg, 1'b1};
    assign size_dec     = size_reg - 1'b1;
    assign parent_idx   = (i_reg - 1'b1) >> 1;
    assign req_row_addr = {req_reg.layer, req_reg.row};

    aoce_ram #(.WIDTH(EntryW), .DEPTH(OpenDepth)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_q)
    );

    aoce_ram #(.WIDTH(BmRowW), .DEPTH(BmDepth)) u_bitmap (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_q)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            size_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            clr_reg   <= clr_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        v_reg      <= v_next;
        e_reg      <= e_next;
        c_reg      <= c_next;
        ci_reg     <= ci_next;
        i_reg      <= i_next;
        disc_reg   <= disc_next;
        closed_reg <= closed_next;
        status_reg <= status_next;
        exp_reg    <= exp_next;
        found_reg  <= found_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == BmAw'(BmDepth - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.opcode == OP_PUSH)
                    begin
                        state_next = (size_reg == CountW'(OpenDepth)) ? S_DONE : S_PU_CHK;
                    end
                    else if (req.opcode == OP_POP)
                    begin
                        state_next = (size_reg == '0) ? S_DONE : S_PO_ROOT;
                    end
                    else
                    begin
                        state_next = S_BM;
                    end
                end
            end
            S_PU_CHK:  state_next = (i_reg == '0) ? S_DONE : S_PU_CMP;
            S_PU_CMP:  state_next = (v_reg < h_q) ? S_PU_CHK : S_DONE;
            S_PO_ROOT: state_next = S_PO_LAST;
            S_PO_LAST: state_next = S_SD_L;
            S_SD_L:    state_next = (left_idx >= size_reg) ? S_PO_NEXT : S_SD_LQ;
            S_SD_LQ:   state_next = ((ci_reg + 1'b1) < size_reg) ? S_SD_RQ : S_SD_CMP;
            S_SD_RQ:   state_next = S_SD_CMP;
            S_SD_CMP:  state_next = (c_reg < v_reg) ? S_SD_L : S_PO_NEXT;
            S_PO_NEXT:
            begin
                if (closed_reg && size_reg != '0)
                begin
                    state_next = S_PO_ROOT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BM:      state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next    = req_reg;
        v_next      = v_reg;
        e_next      = e_reg;
        c_next      = c_reg;
        ci_next     = ci_reg;
        i_next      = i_reg;
        size_next   = size_reg;
        disc_next   = disc_reg;
        closed_next = closed_reg;
        status_next = status_reg;
        exp_next    = exp_reg;
        found_next  = found_reg;
        clr_next    = clr_reg;
        h_we        = 1'b0;
        h_waddr     = i_reg;
        h_wdata     = v_reg;
        h_raddr     = '0;
        b_we        = 1'b0;
        b_waddr     = req_row_addr;
        b_wdata     = b_q;
        b_raddr     = req_row_addr;
        case (state_reg)
            // bitmap sweep after reset
            S_CLEAR:
            begin
                b_we     = 1'b1;
                b_waddr  = clr_reg;
                b_wdata  = '0;
                clr_next = clr_reg + 1'b1;
            end
            // take a request
            S_IDLE:
            begin
                req_next    = req;
                status_next = ST_OK;
                exp_next    = 1'b0;
                found_next  = 1'b0;
                disc_next   = '0;
                v_next      = '{cost: req.cost, handle: req.node_handle,
                                row: req.row, col: req.col, layer: req.layer};
                i_next      = size_reg[HeapAw-1:0];
                h_raddr     = '0;
                b_raddr     = {req.layer, req.row};
                if (start)
                begin
                    if (req.opcode == OP_PUSH)
                    begin
                        if (size_reg == CountW'(OpenDepth))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            size_next = size_reg + 1'b1;
                        end
                    end
                    else if (req.opcode == OP_POP && size_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                end
            end
            // sift up: read parent or place at root
            S_PU_CHK:
            begin
                h_raddr = parent_idx;
                if (i_reg == '0)
                begin
                    h_we = 1'b1;
                end
            end
            S_PU_CMP:
            begin
                h_we = 1'b1;
                if (v_reg < h_q)
                begin
                    h_wdata = h_q;
                    i_next  = parent_idx;
                end
            end
            // root captured, fetch last entry and closed row of root
            S_PO_ROOT:
            begin
                e_next    = h_q;
                size_next = size_dec;
                h_raddr   = size_dec[HeapAw-1:0];
                b_raddr   = {h_q.layer, h_q.row};
            end
            S_PO_LAST:
            begin
                v_next      = h_q;
                i_next      = '0;
                closed_next = b_q[e_reg.col];
            end
            // sift down: fetch left child
            S_SD_L:
            begin
                h_raddr = left_idx[HeapAw-1:0];
                ci_next = left_idx;
                if (left_idx >= size_reg)
                begin
                    h_we = 1'b1;
                end
            end
            S_SD_LQ:
            begin
                c_next  = h_q;
                h_raddr = HeapAw'(ci_reg + 1'b1);
            end
            S_SD_RQ:
            begin
                if (h_q < c_reg)
                begin
                    c_next  = h_q;
                    ci_next = ci_reg + 1'b1;
                end
            end
            S_SD_CMP:
            begin
                h_we = 1'b1;
                if (c_reg < v_reg)
                begin
                    h_wdata = c_reg;
                    i_next  = ci_reg[HeapAw-1:0];
                end
            end
            // decide on the removed entry
            S_PO_NEXT:
            begin
                h_raddr = '0;
                if (closed_reg)
                begin
                    disc_next = disc_reg + 1'b1;
                    if (size_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                else
                begin
                    found_next = 1'b1;
                end
            end
            // closed bitmap mark or query
            S_BM:
            begin
                if (req_reg.opcode == OP_MARK)
                begin
                    b_we                 = 1'b1;
                    b_wdata[req_reg.col] = 1'b1;
                    exp_next             = 1'b1;
                end
                else
                begin
                    exp_next = b_q[req_reg.col];
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // response
    always_comb
    begin
        busy                = (state_reg != S_IDLE);
        done                = (state_reg == S_DONE);
        rsp.status          = status_reg;
        rsp.expanded        = exp_reg;
        rsp.best_row        = found_reg ? e_reg.row : '0;
        rsp.best_col        = found_reg ? e_reg.col : '0;
        rsp.best_layer      = found_reg ? e_reg.layer : '0;
        rsp.best_cost       = found_reg ? e_reg.cost : '0;
        rsp.best_handle     = found_reg ? e_reg.handle : '0;
        rsp.discarded_count = disc_reg;
        rsp.open_count      = size_reg;
    end

endmodule
